// ----- hdl/mcpf_pkg.sv -----
// ----------------------------------------------------------------------------
// mcpf_pkg
// Types and fixed constants shared by the multi-channel pipe table and its
// checker.
// ----------------------------------------------------------------------------
package mcpf_pkg;

  localparam int OP_W     = 2;
  localparam int ID_W     = 16;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int USERS_W  = 8;

  localparam logic [USERS_W-1:0] USERS_MAX = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOPIPE  = 3'd1,
    ST_NOSLOT  = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_USERSAT = 3'd5
  } status_t;

endpackage

// ----- hdl/mcpf_ram.sv -----
// ----------------------------------------------------------------------------
// mcpf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read.
// ----------------------------------------------------------------------------
module mcpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/multi_channel_pipe_fifo.sv -----
// ----------------------------------------------------------------------------
// multi_channel_pipe_fifo
// A table of byte pipes named by 16-bit ids. Each pipe is a ring buffer with
// a fill count and a count of attached users; open, close, write and read
// are served one word per cycle while the result side is not stalled.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Payload
//   in_       input      in_valid/in_stall   in_op, in_pipe_id, in_data
//   out_      output     out_valid/out_stall out_status, out_read_data,
//                                            out_users
//
// One word is accepted per cycle for as long as the result side keeps up.
// A word sits in the input register, where the id compare over all slots and
// the table update are done, until the result register that drives out_ is
// free to take it. The byte store is a RAM with a registered read, whose
// output lines up with the result register. Reset is synchronous and clears
// the slot table; the byte store is not cleared, as only bytes written since
// a pipe was claimed are read.
// While out_stall holds a result, one more word can still be taken into the
// input register before in_stall rises.
//
module multi_channel_pipe_fifo #(
  parameter int NUM_PIPES  = 8,
  parameter int PIPE_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mcpf_pkg::OP_W-1:0]       in_op,
  input  logic [mcpf_pkg::ID_W-1:0]       in_pipe_id,
  input  logic [mcpf_pkg::BYTE_W-1:0]     in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mcpf_pkg::STATUS_W-1:0]   out_status,
  output logic [mcpf_pkg::BYTE_W-1:0]     out_read_data,
  output logic [mcpf_pkg::USERS_W-1:0]    out_users
);

  import mcpf_pkg::*;

  // Slot index, ring pointer and fill count widths. Byte store addresses are
  // the slot index above the ring pointer, so each pipe owns an aligned block.
  localparam int SLOT_W    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int PTR_W     = $clog2(PIPE_DEPTH);
  localparam int CNT_W     = $clog2(PIPE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_PIPES * (2 ** PTR_W);
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(PIPE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(PIPE_DEPTH);

  // Input register.
  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [ID_W-1:0]   s1_id_r;
  logic [BYTE_W-1:0] s1_data_r;

  // Slot table and its next values.
  logic [NUM_PIPES-1:0] slot_used_r, slot_used_nxt;
  logic [ID_W-1:0]      slot_id_r   [NUM_PIPES];
  logic [ID_W-1:0]      slot_id_nxt [NUM_PIPES];
  logic [PTR_W-1:0]     head_r      [NUM_PIPES];
  logic [PTR_W-1:0]     head_nxt    [NUM_PIPES];
  logic [PTR_W-1:0]     tail_r      [NUM_PIPES];
  logic [PTR_W-1:0]     tail_nxt    [NUM_PIPES];
  logic [CNT_W-1:0]     fill_r      [NUM_PIPES];
  logic [CNT_W-1:0]     fill_nxt    [NUM_PIPES];
  logic [USERS_W-1:0]   users_r     [NUM_PIPES];
  logic [USERS_W-1:0]   users_nxt   [NUM_PIPES];

  // Result register. The read byte itself sits in the RAM's output register.
  logic               out_valid_r;
  status_t            out_status_r;
  logic [USERS_W-1:0] out_users_r;
  logic               out_rd_r;

  logic               out_free;
  logic               s1_fire;

  logic [NUM_PIPES-1:0] match;
  logic                 hit;
  logic [SLOT_W-1:0]    hit_idx;
  logic                 free_any;
  logic [SLOT_W-1:0]    free_idx;

  logic [SLOT_W-1:0]  sel;
  logic [USERS_W-1:0] cur_users;
  status_t            status_res;
  logic [USERS_W-1:0] users_res;
  logic               rd_ok;
  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [BYTE_W-1:0]  ram_q;

  // The result register is free when empty or being taken this cycle. The
  // input register moves on whenever it can hand its word over.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  // Parallel id compare over every slot; the lowest matching slot wins, as
  // does the lowest free slot when a new pipe is claimed.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = 0; i < NUM_PIPES; i++) begin
      match[i] = slot_used_r[i] && (slot_id_r[i] == s1_id_r);
    end
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!slot_used_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Operation decode and table update.
  always_comb begin
    slot_used_nxt = slot_used_r;
    slot_id_nxt   = slot_id_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    users_nxt     = users_r;
    status_res    = ST_OK;
    users_res     = '0;
    rd_ok         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    sel           = hit ? hit_idx : free_idx;
    cur_users     = users_r[sel];

    case (s1_op_r)
      OP_OPEN: begin
        // A freshly claimed slot starts from a zero user count.
        if (!hit) begin
          cur_users = '0;
        end
        if (!hit && !free_any) begin
          status_res = ST_NOSLOT;
        end else if (cur_users == USERS_MAX) begin
          status_res = ST_USERSAT;
          users_res  = USERS_MAX;
        end else begin
          users_nxt[sel] = cur_users + USERS_W'(1);
          users_res      = cur_users + USERS_W'(1);
          if (!hit) begin
            slot_used_nxt[sel] = 1'b1;
            slot_id_nxt[sel]   = s1_id_r;
            head_nxt[sel]      = '0;
            tail_nxt[sel]      = '0;
            fill_nxt[sel]      = '0;
          end
        end
      end
      OP_CLOSE: begin
        if (!hit) begin
          status_res = ST_NOPIPE;
        end else begin
          // A count already at zero stays there and the slot is still freed.
          if (cur_users != '0) begin
            users_nxt[sel] = cur_users - USERS_W'(1);
          end
          if (cur_users <= USERS_W'(1)) begin
            slot_used_nxt[sel] = 1'b0;
          end
          users_res = users_nxt[sel];
        end
      end
      OP_WRITE: begin
        if (!hit) begin
          status_res = ST_NOPIPE;
        end else begin
          users_res = cur_users;
          if (fill_r[sel] >= FULL_CNT) begin
            status_res = ST_FULL;
          end else begin
            ram_we        = 1'b1;
            tail_nxt[sel] = (tail_r[sel] == LAST_PTR) ? '0 : tail_r[sel] + PTR_W'(1);
            fill_nxt[sel] = fill_r[sel] + CNT_W'(1);
          end
        end
      end
      OP_READ: begin
        if (!hit) begin
          status_res = ST_NOPIPE;
        end else begin
          users_res = cur_users;
          if (fill_r[sel] == '0) begin
            status_res = ST_EMPTY;
          end else begin
            rd_ok         = 1'b1;
            ram_re        = 1'b1;
            head_nxt[sel] = (head_r[sel] == LAST_PTR) ? '0 : head_r[sel] + PTR_W'(1);
            fill_nxt[sel] = fill_r[sel] - CNT_W'(1);
          end
        end
      end
      default: begin
        status_res = ST_OK;
      end
    endcase
  end

  assign ram_wr_addr = ADDR_W'({sel, tail_r[sel]});
  assign ram_rd_addr = ADDR_W'({sel, head_r[sel]});

  mcpf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_byte_store (
    .clk     (clk),
    .wr_en   (ram_we && s1_fire),
    .wr_addr (ram_wr_addr),
    .wr_data (s1_data_r),
    .rd_en   (ram_re && s1_fire),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_q)
  );

  // Input register: takes a word whenever it is empty or handing over.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_op_r   <= op_t'(in_op);
      s1_id_r   <= in_pipe_id;
      s1_data_r <= in_data;
    end
  end

  // Slot table: updated once for each word that leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
      for (int i = 0; i < NUM_PIPES; i++) begin
        slot_id_r[i] <= '0;
        head_r[i]    <= '0;
        tail_r[i]    <= '0;
        fill_r[i]    <= '0;
        users_r[i]   <= '0;
      end
    end else if (s1_fire) begin
      slot_used_r <= slot_used_nxt;
      slot_id_r   <= slot_id_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      users_r     <= users_nxt;
    end
  end

  // Result register. The RAM read is enabled only together with a load here,
  // so its output stays matched to the held result while the output stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_fire) begin
      out_status_r <= status_res;
      out_users_r  <= users_res;
      out_rd_r     <= rd_ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_users     = out_users_r;
  assign out_read_data = out_rd_r ? ram_q : '0;

endmodule

// ----- hdl/mcpf_checker.sv -----
// ----------------------------------------------------------------------------
// mcpf_checker
// Port-level checks on the pipe table's results, bound to the top level.
// ----------------------------------------------------------------------------
module mcpf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mcpf_pkg::STATUS_W-1:0] out_status,
  input logic [mcpf_pkg::BYTE_W-1:0]   out_read_data,
  input logic [mcpf_pkg::USERS_W-1:0]  out_users
);

  import mcpf_pkg::*;

  // Only a successful read returns a byte other than zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_data != '0) |-> out_status == ST_OK)
    else $error("mcpf: read byte returned with a failing status");

  // With no pipe found or claimed, the user count reads zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOPIPE || out_status == ST_NOSLOT)
      |-> out_users == '0)
    else $error("mcpf: user count given without a pipe");

  // A saturated open reports the full user count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_USERSAT |-> out_users == USERS_MAX)
    else $error("mcpf: saturated status without full user count");

  // A stalled result word stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_read_data) && $stable(out_users))
    else $error("mcpf: stalled result changed");

endmodule

bind multi_channel_pipe_fifo mcpf_checker u_mcpf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_read_data (out_read_data),
  .out_users     (out_users)
);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-channel pipe table. A short table of
// directed words is followed by a user-saturation phase and random bursts of
// pipe traffic; every result is checked against a predictor or a pinned row.
// ----------------------------------------------------------------------------
module tb_top;

  import mcpf_pkg::*;

  localparam int NUM_PIPES      = 8;
  localparam int PIPE_DEPTH     = 64;
  localparam int RANDOM_WORDS   = 110;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;
  localparam int POOL_SIZE      = 12;
  localparam logic [ID_W-1:0] SAT_ID = 16'h8001;

  // One result as it leaves the block.
  typedef struct packed {
    status_t             st;
    logic [BYTE_W-1:0]   rd;
    logic [USERS_W-1:0]  us;
  } pipe_result_t;

  // One row of the directed part. Where pin is set, the result typed in the
  // row is what must come back; otherwise the predictor decides.
  typedef struct packed {
    op_t                op;
    logic [ID_W-1:0]    id;
    logic [BYTE_W-1:0]  data;
    bit                 pin;
    pipe_result_t       res;
  } dir_row_t;

  localparam pipe_result_t NO_PIN = '{ST_OK, 8'h00, 8'h00};

  localparam dir_row_t DIR_ROWS [22] = '{
    // Nothing is open after reset, so every id is unknown.
    '{OP_READ,  16'h0000, 8'h00, 1'b1, '{ST_NOPIPE, 8'h00, 8'h00}},
    '{OP_WRITE, 16'hFFFF, 8'hFF, 1'b1, '{ST_NOPIPE, 8'h00, 8'h00}},
    '{OP_CLOSE, 16'h8000, 8'h00, 1'b1, '{ST_NOPIPE, 8'h00, 8'h00}},
    // Open the two extreme ids; a second open of the same id adds a user.
    '{OP_OPEN,  16'h0000, 8'h00, 1'b1, '{ST_OK,     8'h00, 8'h01}},
    '{OP_OPEN,  16'hFFFF, 8'h00, 1'b1, '{ST_OK,     8'h00, 8'h01}},
    '{OP_OPEN,  16'h0000, 8'h00, 1'b1, '{ST_OK,     8'h00, 8'h02}},
    '{OP_READ,  16'h0000, 8'h00, 1'b1, '{ST_EMPTY,  8'h00, 8'h02}},
    // Extreme bytes through two pipes; they must come out in order.
    '{OP_WRITE, 16'h0000, 8'h00, 1'b0, NO_PIN},
    '{OP_WRITE, 16'h0000, 8'hFF, 1'b0, NO_PIN},
    '{OP_WRITE, 16'hFFFF, 8'hA5, 1'b0, NO_PIN},
    '{OP_READ,  16'h0000, 8'h00, 1'b0, NO_PIN},
    '{OP_READ,  16'h0000, 8'h00, 1'b0, NO_PIN},
    '{OP_READ,  16'hFFFF, 8'h00, 1'b0, NO_PIN},
    // Fill the rest of the table, then one open too many.
    '{OP_OPEN,  16'h0001, 8'h00, 1'b0, NO_PIN},
    '{OP_OPEN,  16'h0002, 8'h00, 1'b0, NO_PIN},
    '{OP_OPEN,  16'h0003, 8'h00, 1'b0, NO_PIN},
    '{OP_OPEN,  16'h0004, 8'h00, 1'b0, NO_PIN},
    '{OP_OPEN,  16'h0005, 8'h00, 1'b0, NO_PIN},
    '{OP_OPEN,  16'h0006, 8'h00, 1'b0, NO_PIN},
    '{OP_OPEN,  16'h0007, 8'h00, 1'b1, '{ST_NOSLOT, 8'h00, 8'h00}},
    // Two closes free the first slot again.
    '{OP_CLOSE, 16'h0000, 8'h00, 1'b0, NO_PIN},
    '{OP_CLOSE, 16'h0000, 8'h00, 1'b1, '{ST_OK,     8'h00, 8'h00}}
  };

  // Clock and block ports. Every input has a known value from time zero.
  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_op         = '0;
  logic [ID_W-1:0]     in_pipe_id    = '0;
  logic [BYTE_W-1:0]   in_data       = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [BYTE_W-1:0]   out_read_data;
  logic [USERS_W-1:0]  out_users;

  // Pinned result travelling alongside the word on offer.
  bit                  word_pin      = 1'b0;
  pipe_result_t        word_pin_res  = NO_PIN;

  // Predictor state: one entry per slot of the pipe table.
  bit                  chan_open  [NUM_PIPES];
  bit [ID_W-1:0]       chan_tag   [NUM_PIPES];
  int                  rd_ptr     [NUM_PIPES];
  int                  wr_ptr     [NUM_PIPES];
  int                  chan_fill  [NUM_PIPES];
  bit [USERS_W-1:0]    chan_users [NUM_PIPES];
  bit [BYTE_W-1:0]     chan_bytes [NUM_PIPES][PIPE_DEPTH];

  pipe_result_t        pending_replies [$];
  logic [ID_W-1:0]     id_pool [POOL_SIZE];

  int                  mismatches    = 0;
  int                  results_seen  = 0;
  int                  rand_words    = 0;
  int                  quiet_cycles  = 0;
  bit                  send_gaps_on  = 1'b1;
  bit                  recv_gaps_on  = 1'b1;
  bit                  hold_req      = 1'b0;

  multi_channel_pipe_fifo #(
    .NUM_PIPES  (NUM_PIPES),
    .PIPE_DEPTH (PIPE_DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_pipe_id    (in_pipe_id),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_read_data (out_read_data),
    .out_users     (out_users)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Works out the result of one word and updates the predicted table. The
  // id search walks downwards so that the lowest matching slot wins, and the
  // same goes for the search for a free slot.
  function automatic pipe_result_t apply_pipe_op(op_t op, logic [ID_W-1:0] id,
                                                 logic [BYTE_W-1:0] data);
    pipe_result_t r;
    int s;
    r = NO_PIN;
    s = -1;
    for (int i = NUM_PIPES - 1; i >= 0; i--)
      if (chan_open[i] && chan_tag[i] == id) s = i;
    if (op == OP_OPEN) begin
      if (s < 0) begin
        for (int i = NUM_PIPES - 1; i >= 0; i--)
          if (!chan_open[i]) s = i;
        if (s >= 0) begin
          chan_open[s]  = 1'b1;
          chan_tag[s]   = id;
          rd_ptr[s]     = 0;
          wr_ptr[s]     = 0;
          chan_fill[s]  = 0;
          chan_users[s] = '0;
        end
      end
      if (s < 0) begin
        r.st = ST_NOSLOT;
      end else if (chan_users[s] == USERS_MAX) begin
        r.st = ST_USERSAT;
        r.us = USERS_MAX;
      end else begin
        chan_users[s] = chan_users[s] + 1'b1;
        r.us = chan_users[s];
      end
    end else if (s < 0) begin
      r.st = ST_NOPIPE;
    end else if (op == OP_CLOSE) begin
      if (chan_users[s] != 0) chan_users[s] = chan_users[s] - 1'b1;
      if (chan_users[s] == 0) chan_open[s] = 1'b0;
      r.us = chan_users[s];
    end else if (op == OP_WRITE) begin
      r.us = chan_users[s];
      if (chan_fill[s] >= PIPE_DEPTH) begin
        r.st = ST_FULL;
      end else begin
        chan_bytes[s][wr_ptr[s]] = data;
        wr_ptr[s] = (wr_ptr[s] + 1) % PIPE_DEPTH;
        chan_fill[s]++;
      end
    end else begin
      r.us = chan_users[s];
      if (chan_fill[s] == 0) begin
        r.st = ST_EMPTY;
      end else begin
        r.rd = chan_bytes[s][rd_ptr[s]];
        rd_ptr[s] = (rd_ptr[s] + 1) % PIPE_DEPTH;
        chan_fill[s]--;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("ERROR at %0t, result %0d: %s", $time, results_seen, what);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) return ID_W'($urandom_range(0, 65535));
    return id_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Offers one word at a falling edge, after an optional random gap, and returns at the rising
  // edge that takes it. Valid stays high into the next call, so back-to-back
  // words never see valid drop.
  task automatic send_word(op_t op, logic [ID_W-1:0] id, logic [BYTE_W-1:0] data,
                           bit pin, pipe_result_t pinned);
    int gap;
    gap = (send_gaps_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_pipe_id   <= id;
    in_data      <= data;
    word_pin     <= pin;
    word_pin_res <= pinned;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic send_rand(op_t op, logic [ID_W-1:0] id, logic [BYTE_W-1:0] data);
    send_word(op, id, data, 1'b0, NO_PIN);
    rand_words++;
  endtask

  // The sender goes quiet until every outstanding result has been taken.
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // One burst of random traffic. Most bursts are well-formed pipe use on the
  // pooled ids (opens, fills, drains); plain mixed words and stray ids from
  // the whole range make up the noise.
  task automatic run_burst();
    logic [ID_W-1:0] id;
    int kind;
    int n;
    send_gaps_on = ($urandom_range(0, 3) != 0);
    recv_gaps_on = ($urandom_range(0, 3) != 0);
    kind = $urandom_range(0, 9);
    id   = pick_id();
    n    = $urandom_range(0, 1) ? PIPE_DEPTH + 3 : $urandom_range(2, 16);
    case (kind)
      0, 1, 2, 3: begin
        repeat (8) send_rand(op_t'($urandom_range(0, 3)), pick_id(),
                             BYTE_W'($urandom_range(0, 255)));
      end
      4: begin
        // Open a pipe and write into it, often well past full.
        send_rand(OP_OPEN, id, BYTE_W'($urandom_range(0, 255)));
        repeat (n) send_rand(OP_WRITE, id, BYTE_W'($urandom_range(0, 255)));
      end
      5: begin
        // Drain a pipe, often well past empty.
        repeat (n) send_rand(OP_READ, id, BYTE_W'($urandom_range(0, 255)));
      end
      6: begin
        foreach (id_pool[i]) send_rand(OP_CLOSE, id_pool[i], BYTE_W'($urandom_range(0, 255)));
      end
      7: begin
        // More pooled ids than slots, so the table runs out.
        foreach (id_pool[i]) send_rand(OP_OPEN, id_pool[i], BYTE_W'($urandom_range(0, 255)));
      end
      default: begin
        repeat (16) send_rand($urandom_range(0, 1) ? OP_WRITE : OP_READ, id,
                              BYTE_W'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Input side: every accepted word is run through the predictor, and its
  // result, or the pinned one from the directed table, is queued.
  always @(posedge clk) begin : word_taken
    pipe_result_t predicted;
    if (rst_n && in_valid && !in_stall) begin
      predicted = apply_pipe_op(op_t'(in_op), in_pipe_id, in_data);
      pending_replies.push_back(word_pin ? word_pin_res : predicted);
    end
  end

  // Result side: each accepted result is checked against the oldest entry.
  always @(posedge clk) begin : result_taken
    pipe_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding (status %0d)",
                                  out_status));
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.st)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.st));
        if (out_read_data !== want.rd)
          report_mismatch($sformatf("read_data 0x%02h, expected 0x%02h",
                                    out_read_data, want.rd));
        if (out_users !== want.us)
          report_mismatch($sformatf("users %0d, expected %0d", out_users, want.us));
      end
    end
  end

  // Receiver. Stalls of random length when enabled; on request one long
  // hold-off, so that the block backs up and raises in_stall.
  initial begin : result_stall
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (recv_gaps_on && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        repeat (pick_gap()) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Watchdog: counts cycles in which neither side moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    // The pool holds the extreme ids, the ids left open by the directed
    // part and a few random ones, which is more than there are slots.
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) id_pool[i] = ID_W'(i - 1);
    for (int i = 8; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom_range(0, 65535));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i])
      send_word(DIR_ROWS[i].op, DIR_ROWS[i].id, DIR_ROWS[i].data,
                DIR_ROWS[i].pin, DIR_ROWS[i].res);
    pause_until_drained();

    // User saturation on the one free slot. The receiver holds off at the
    // start while the sender keeps offering words with no gaps at all.
    send_gaps_on = 1'b0;
    hold_req     = 1'b1;
    repeat (USERS_MAX + 1)
      send_word(OP_OPEN, SAT_ID, BYTE_W'($urandom_range(0, 255)), 1'b0, NO_PIN);
    pause_until_drained();
    send_gaps_on = 1'b1;

    while (rand_words < RANDOM_WORDS) run_burst();
    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- multi_channel_pipe_fifo.f -----
hdl/mcpf_pkg.sv
hdl/mcpf_ram.sv
hdl/multi_channel_pipe_fifo.sv
hdl/mcpf_checker.sv
bench/tb_top.sv
